[sv/vef_pkg.sv]
// vef_pkg: shared types and character constants of the visible escape folder.
// Used by vef_encoder and visible_escape_folder_top; depends on nothing.
package vef_pkg;

	// most output bytes one input word can cause
	localparam int unsigned MaxRun = 6;
	localparam int unsigned RunW   = 3;

	// characters that appear in the visible form
	localparam logic [7:0] ChBslash = 8'h5C;
	localparam logic [7:0] ChLf     = 8'h0A;
	localparam logic [7:0] ChDollar = 8'h24;
	localparam logic [7:0] ChZero   = 8'h30;
	localparam logic [7:0] ChSpace  = 8'h20;
	localparam logic [7:0] ChTilde  = 8'h7E;

	// control bytes that have a two-character escape
	localparam logic [7:0] CtlBel = 8'h07;
	localparam logic [7:0] CtlBs  = 8'h08;
	localparam logic [7:0] CtlTab = 8'h09;
	localparam logic [7:0] CtlVt  = 8'h0B;
	localparam logic [7:0] CtlFf  = 8'h0C;
	localparam logic [7:0] CtlCr  = 8'h0D;

	// register index of the configuration port
	localparam logic RegFoldLimit = 1'b0;
	localparam logic [7:0] FoldLimitReset = 8'd80;

	// expansion of one input word
	typedef struct packed {
		logic [MaxRun-1:0][7:0] bytes;    // bytes[0] goes out first
		logic [RunW-1:0]        len;      // 1..6
		logic [7:0]             col_next; // column count after this word
	} vef_run_t;

endpackage

[sv/visible_escape_folder_top.sv]
// visible_escape_folder_top: stream wrapper with column state, run buffer and
// APB register for the visible escape folder. Depends on vef_pkg, vef_encoder.
//
// Usage: text words enter on the s_ group (s_tdata = text byte, s_tlast = end
// of text). Each word expands into a run of 1 to 6 output words on the m_
// group (m_tdata = visible byte, m_tlast = last word of the run). fold_limit
// is written through the APB port at address 0; the user must write it only
// while the block is idle, as the block itself does not enforce this. The
// first word of a run is valid the cycle after the input word is accepted.
// A new word is taken in the same cycle as the last word of the previous run
// leaves, so one-byte runs flow at one word per cycle while m_tready is high.
// The run buffer, drained one byte per cycle while m_tready is high, sets it.
// Reset clears the column count, empties the run buffer and sets fold_limit
// to 80. When the receiver stalls, the current output word holds and
// s_tready stays low until the run's last word is taken.
module visible_escape_folder_top (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] text_byte
	input  logic        s_tlast,  // end_of_text
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [7:0] out_byte
	output logic        m_tlast,  // last_of_run
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0]                       fold_limit_q;
	logic [7:0]                       col_q;
	logic [vef_pkg::MaxRun-1:0][7:0]  buf_q;
	logic [vef_pkg::RunW-1:0]         rem_q;
	vef_pkg::vef_run_t                run;
	logic                             in_fire;
	logic                             out_fire;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == vef_pkg::RegFoldLimit) ? {24'd0, fold_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_limit_q <= vef_pkg::FoldLimitReset;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == vef_pkg::RegFoldLimit) begin
			fold_limit_q <= pwdata[7:0];
		end
	end

	// expansion of the incoming word
	vef_encoder u_enc (
		.text_byte  (s_tdata),
		.end_of_text(s_tlast),
		.col        (col_q),
		.fold_limit (fold_limit_q),
		.run        (run)
	);

	// handshakes
	assign m_tvalid = (rem_q != '0);
	assign m_tdata  = buf_q[0];
	assign m_tlast  = (rem_q == 3'd1);
	assign out_fire = m_tvalid && m_tready;
	assign s_tready = (rem_q == '0) || (m_tready && rem_q == 3'd1);
	assign in_fire  = s_tvalid && s_tready;

	// column count and run length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= 8'd0;
			rem_q <= '0;
		end else if (in_fire) begin
			col_q <= run.col_next;
			rem_q <= run.len;
		end else if (out_fire) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	// run buffer: load on accept, shift down on each output word
	always_ff @(posedge clk) begin
		if (in_fire) begin
			buf_q <= run.bytes;
		end else if (out_fire) begin
			for (int k = 0; k < vef_pkg::MaxRun - 1; k++)
				buf_q[k] <= buf_q[k + 1];
			buf_q[vef_pkg::MaxRun - 1] <= 8'h00;
		end
	end

	// checks
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready) else $error("input blocked with empty buffer");

	a_run_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> m_tvalid) else $error("accepted word produced no output");

	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= 3'(vef_pkg::MaxRun)) else $error("run length out of range");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && s_tlast) |=> (col_q == 8'd0)) else $error("end did not clear column");

endmodule

[sv/vef_encoder.sv]
// vef_encoder: combinational expansion of one text byte into its visible run,
// including the fold check and column update. Depends on vef_pkg.
module vef_encoder (
	input  logic [7:0]       text_byte,
	input  logic             end_of_text,
	input  logic [7:0]       col,
	input  logic [7:0]       fold_limit,
	output vef_pkg::vef_run_t run
);

	logic                 fold;
	logic [7:0]           col_base;
	logic [3:0][7:0]      body;
	logic [vef_pkg::RunW-1:0] body_len;
	logic [2:0]           add;
	logic                 set_col;
	logic [7:0]           set_val;
	logic [7:0]           esc;
	logic [8:0]           sum;

	// fold before a text byte once the line ran past the limit
	assign fold     = !end_of_text && (col > fold_limit);
	assign col_base = fold ? 8'd0 : col;

	// two-character escape letters
	always_comb begin
		unique case (text_byte)
			vef_pkg::CtlBel: esc = 8'h61; // a
			vef_pkg::CtlBs:  esc = 8'h62; // b
			vef_pkg::CtlFf:  esc = 8'h66; // f
			vef_pkg::CtlCr:  esc = 8'h72; // r
			vef_pkg::CtlTab: esc = 8'h74; // t
			vef_pkg::CtlVt:  esc = 8'h76; // v
			default:         esc = 8'h00;
		endcase
	end

	// body of the run, without the fold prefix
	always_comb begin
		body     = '0;
		body_len = 3'd1;
		add      = 3'd0;
		set_col  = 1'b0;
		set_val  = 8'd0;
		priority if (end_of_text) begin
			body[0]  = vef_pkg::ChDollar;
			body[1]  = vef_pkg::ChLf;
			body_len = 3'd2;
			set_col  = 1'b1;
			set_val  = 8'd0;
		end else if (text_byte >= vef_pkg::ChSpace && text_byte <= vef_pkg::ChTilde) begin
			if (text_byte == vef_pkg::ChBslash) begin
				body[0]  = vef_pkg::ChBslash;
				body[1]  = vef_pkg::ChBslash;
				body_len = 3'd2;
				add      = 3'd2;
			end else begin
				body[0]  = text_byte;
				body_len = 3'd1;
				add      = 3'd1;
			end
		end else if (text_byte == vef_pkg::ChLf) begin
			body[0]  = vef_pkg::ChDollar;
			body[1]  = vef_pkg::ChLf;
			body_len = 3'd2;
			set_col  = 1'b1;
			set_val  = 8'd1;
		end else if (esc != 8'h00) begin
			body[0]  = vef_pkg::ChBslash;
			body[1]  = esc;
			body_len = 3'd2;
			add      = 3'd2;
		end else begin
			// octal escape, most significant digit first
			body[0]  = vef_pkg::ChBslash;
			body[1]  = vef_pkg::ChZero + {6'd0, text_byte[7:6]};
			body[2]  = vef_pkg::ChZero + {5'd0, text_byte[5:3]};
			body[3]  = vef_pkg::ChZero + {5'd0, text_byte[2:0]};
			body_len = 3'd4;
			add      = 3'd4;
		end
	end

	// saturating column update
	assign sum = {1'b0, col_base} + {6'd0, add};

	// place the fold prefix ahead of the body; run length and next column
	always_comb begin
		run.col_next = set_col ? set_val : (sum[8] ? 8'hFF : sum[7:0]);
		run.len      = body_len + (fold ? 3'd2 : 3'd0);
		for (int i = 0; i < vef_pkg::MaxRun; i++) begin
			if (fold) begin
				if (i == 0)
					run.bytes[i] = vef_pkg::ChBslash;
				else if (i == 1)
					run.bytes[i] = vef_pkg::ChLf;
				else
					run.bytes[i] = body[2'(i - 2)];
			end else if (i < 4) begin
				run.bytes[i] = body[2'(i)];
			end else begin
				run.bytes[i] = 8'h00;
			end
		end
	end

endmodule
